FILE: rtl/ycdxt_pkg.sv
// Package for the YCoCg DXT block compressor: shared types, constants and helpers.
// No dependencies.
package ycdxt_pkg;

	localparam int unsigned NumPix = 16;
	localparam logic [7:0] Mid = 8'd128;
	localparam logic [7:0] Keep5 = 8'hf8;
	localparam logic [7:0] Keep6 = 8'hfc;

	typedef logic [3:0] pix_idx_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture one pixel
		logic prep;      // clear diagonal count
		logic scale;     // scale endpoints
		logic thresh;    // Cg/Co midpoints and alpha thresholds
		logic walk;      // per-pixel pass
		logic finish;    // diagonal decision, assemble result
		pix_idx_t idx;
	} dp_cmd_t;

	typedef struct packed {
		logic last_pix;
		logic cpass;     // color index pass still running
	} dp_sts_t;

	// Scale about mid-grey, modulo 256
	function automatic logic [7:0] scale_mid(input logic [7:0] v, input logic [2:0] s);
		logic [10:0] t;
		t = (11'(v) + 11'd128) * 11'(s) + 11'd128;
		return t[7:0];
	endfunction

	function automatic logic [8:0] absd(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? 9'(a - b) : 9'(b - a);
	endfunction

	// x/3 for x < 768 by reciprocal multiply: (x*683)>>11
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	// x/7 for x < 1792: (x*4682)>>15 with one correction
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [23:0] p;
		logic [10:0] q;
		logic [10:0] r;
		p = 24'(x) * 24'd4682;
		q = {2'b00, p[23:15]};
		r = x - 11'(q * 11'd7);
		if (r >= 11'd7)
			q = q + 11'd1;
		return q[7:0];
	endfunction

endpackage

FILE: rtl/ycdxt_ctrl.sv
// Controller for the YCoCg DXT block compressor.
// Depends on ycdxt_pkg.
module ycdxt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ycdxt_pkg::dp_sts_t sts,
	output ycdxt_pkg::dp_cmd_t cmd
);
	import ycdxt_pkg::*;

	typedef enum logic [5:0] {
		ST_LOAD   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_SCALE  = 6'b000100,
		ST_THRESH = 6'b001000,
		ST_WALK   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t   state_q;
	pix_idx_t idx_q;
	logic     out_valid_q;
	logic     acc;

	assign in_stall  = (state_q != ST_LOAD);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = acc;
		cmd.prep   = (state_q == ST_PREP);
		cmd.scale  = (state_q == ST_SCALE);
		cmd.thresh = (state_q == ST_THRESH);
		cmd.walk   = (state_q == ST_WALK);
		cmd.finish = (state_q == ST_FINISH) && !sts.cpass && !(out_valid_q && out_stall);
		cmd.idx    = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (acc && sts.last_pix)
						state_q <= ST_PREP;
				end
				ST_PREP:   state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_THRESH;
				ST_THRESH: begin
					idx_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'(NumPix - 1))
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.finish)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

FILE: rtl/ycdxt_dpath.sv
// Datapath for the YCoCg DXT block compressor: pixel store, bounds,
// scaling, endpoint and index coding. Depends on ycdxt_pkg.
module ycdxt_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              format_mode,
	input  logic [7:0]        co_byte,
	input  logic [7:0]        cg_byte,
	input  logic [7:0]        spare_byte,
	input  logic [7:0]        luma_byte,
	input  ycdxt_pkg::dp_cmd_t cmd,
	output ycdxt_pkg::dp_sts_t sts,
	output logic [63:0]       alpha_block,
	output logic [63:0]       color_block
);
	import ycdxt_pkg::*;

	logic [23:0] store_q [NumPix];
	logic [7:0]  min_q [4];
	logic [7:0]  max_q [4];
	pix_idx_t    cnt_q;

	logic [7:0]  mn_q [4];
	logic [7:0]  mx_q [4];
	logic [2:0]  s_q;
	logic        dxt5_q;
	logic [7:0]  p_q [4][2];
	logic [7:0]  th_q [7];
	logic [7:0]  mid0_q, mid1_q;
	logic [4:0]  side_q;
	logic [47:0] abits_q;
	logic [31:0] cbits_q;
	logic [63:0] alpha_q, color_q;

	assign sts.last_pix = (cnt_q == 4'(NumPix - 1));
	assign alpha_block  = alpha_q;
	assign color_block  = color_q;

	// bounds, count and store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int c = 0; c < 4; c++) begin
				min_q[c] <= 8'hff;
				max_q[c] <= 8'h00;
			end
		end else if (cmd.load) begin
			cnt_q <= cnt_q + 4'd1;
			if (co_byte < min_q[0]) min_q[0] <= co_byte;
			if (cg_byte < min_q[1]) min_q[1] <= cg_byte;
			if (spare_byte < min_q[2]) min_q[2] <= spare_byte;
			if (luma_byte < min_q[3]) min_q[3] <= luma_byte;
			if (co_byte > max_q[0]) max_q[0] <= co_byte;
			if (cg_byte > max_q[1]) max_q[1] <= cg_byte;
			if (spare_byte > max_q[2]) max_q[2] <= spare_byte;
			if (luma_byte > max_q[3]) max_q[3] <= luma_byte;
			if (sts.last_pix) begin
				for (int c = 0; c < 4; c++) begin
					min_q[c] <= 8'hff;
					max_q[c] <= 8'h00;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			store_q[cnt_q] <= {co_byte, cg_byte, luma_byte};
	end

	// final bounds including the 16th pixel
	logic [7:0] fmn [4];
	logic [7:0] fmx [4];
	logic [8:0] m0;
	logic [2:0] s_n;
	always_comb begin
		fmn[0] = (co_byte < min_q[0]) ? co_byte : min_q[0];
		fmn[1] = (cg_byte < min_q[1]) ? cg_byte : min_q[1];
		fmn[2] = (spare_byte < min_q[2]) ? spare_byte : min_q[2];
		fmn[3] = (luma_byte < min_q[3]) ? luma_byte : min_q[3];
		fmx[0] = (co_byte > max_q[0]) ? co_byte : max_q[0];
		fmx[1] = (cg_byte > max_q[1]) ? cg_byte : max_q[1];
		fmx[2] = (spare_byte > max_q[2]) ? spare_byte : max_q[2];
		fmx[3] = (luma_byte > max_q[3]) ? luma_byte : max_q[3];
		m0 = absd(mn_q[0], Mid);
		if (absd(mn_q[1], Mid) > m0) m0 = absd(mn_q[1], Mid);
		if (absd(mx_q[0], Mid) > m0) m0 = absd(mx_q[0], Mid);
		if (absd(mx_q[1], Mid) > m0) m0 = absd(mx_q[1], Mid);
		s_n = 3'd1 + ((m0 <= 9'd63) ? 3'd1 : 3'd0) + ((m0 <= 9'd31) ? 3'd2 : 3'd0);
	end

	// per-pixel walk signals
	logic [7:0] px_co, px_cg, px_y;
	logic [9:0] d [4];
	logic       b0, b1, b2, b3, b4;
	logic [1:0] cv;
	logic [3:0] ai;
	always_comb begin
		px_co = store_q[cmd.idx][23:16];
		px_cg = store_q[cmd.idx][15:8];
		px_y  = store_q[cmd.idx][7:0];
		if (dxt5_q) begin
			px_co = scale_mid(px_co, s_q);
			px_cg = scale_mid(px_cg, s_q);
		end
		for (int k = 0; k < 4; k++)
			d[k] = 10'(absd(p_q[k][0], px_co)) + 10'(absd(p_q[k][1], px_cg));
		b0 = d[0] > d[3];
		b1 = d[1] > d[2];
		b2 = d[0] > d[2];
		b3 = d[1] > d[3];
		b4 = d[2] > d[3];
		cv = {(b1 & b2) | (b0 & b3), b0 & b4};
		ai = 4'd1;
		for (int k = 0; k < 7; k++)
			ai = ai + ((px_y <= th_q[k]) ? 4'd1 : 4'd0);
		ai = ai & 4'd7;
		if (ai < 4'd2)
			ai = ai ^ 4'd1;
	end

	// endpoints (after scaling) for color: swap handled at finish
	logic [7:0] pe [2][2];
	logic [7:0] span, mid7;
	logic [10:0] tsum;
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			pe[0][c] = (mx_q[c] & ((c == 0) ? Keep5 : Keep6)) | (mx_q[c] >> ((c == 0) ? 5 : 6));
			pe[1][c] = (mn_q[c] & ((c == 0) ? Keep5 : Keep6)) | (mn_q[c] >> ((c == 0) ? 5 : 6));
		end
		span = (mx_q[3] >= mn_q[3]) ? (mx_q[3] - mn_q[3]) : 8'd0;
		// span/14 as (span/2)/7
		mid7 = div7(11'(span) >> 1);
		tsum = '0;
	end

	logic       swap;
	logic [7:0] fmn1, fmx1;
	logic [15:0] c565mx, c565mn;
	always_comb begin
		swap   = (side_q > 5'd8) && (mn_q[0] != mx_q[0]);
		fmn1   = swap ? mx_q[1] : mn_q[1];
		fmx1   = swap ? mn_q[1] : mx_q[1];
		c565mx = {mx_q[0][7:3], fmx1[7:2], mx_q[2][7:3]};
		c565mn = {mn_q[0][7:3], fmn1[7:2], mn_q[2][7:3]};
	end

	// color indices are not taken from the walk; when the swap applies the
	// Cg endpoints of the block are swapped and the indices are recomputed in
	// the color index pass, which uses the endpoints after the diagonal pass.
	always_ff @(posedge clk) begin
		if (cmd.load && sts.last_pix) begin
			for (int c = 0; c < 4; c++) begin
				mn_q[c] <= fmn[c];
				mx_q[c] <= fmx[c];
			end
			dxt5_q <= !format_mode;
		end
		if (cmd.prep)
			side_q <= '0;
		if (cmd.scale) begin
			s_q <= dxt5_q ? s_n : 3'd1;
			if (dxt5_q) begin
				for (int c = 0; c < 2; c++) begin
					mn_q[c] <= scale_mid(mn_q[c], s_n);
					mx_q[c] <= scale_mid(mx_q[c], s_n);
				end
				mn_q[2] <= {2'b00, s_n - 3'd1, 3'b000};
				mx_q[2] <= {2'b00, s_n - 3'd1, 3'b000};
			end
		end
		if (cmd.thresh) begin
			mid0_q <= 8'((9'(mn_q[0]) + 9'(mx_q[0]) + 9'd1) >> 1);
			mid1_q <= 8'((9'(mn_q[1]) + 9'(mx_q[1]) + 9'd1) >> 1);
			th_q[0] <= mn_q[3] + mid7;
			for (int k = 1; k < 7; k++)
				th_q[k] <= div7(11'(7 - k) * 11'(mx_q[3]) + 11'(k) * 11'(mn_q[3]))
					+ mid7;
		end
		if (cmd.walk) begin
			side_q <= side_q + 5'(((px_co >= mid0_q) ^ (px_cg >= mid1_q)) ? 1 : 0);
			abits_q[3*cmd.idx +: 3] <= ai[2:0];
		end
		if (cmd.finish) begin
			alpha_q <= dxt5_q ? {abits_q, mn_q[3], mx_q[3]} : 64'd0;
			color_q <= {cbits_q, c565mn, c565mx};
		end
	end

	// Color indices depend on the swap, so they are formed in a second
	// pass that runs in the finish window.
	logic [3:0]  fin_idx_q;
	logic        cpass_q;
	logic [7:0]  q [4][2];
	logic [7:0]  pco, pcg;
	logic [9:0]  e [4];
	logic [1:0]  cv2;
	assign sts.cpass = cpass_q;
	always_comb begin
		q[0][0] = pe[0][0];
		q[1][0] = pe[1][0];
		q[0][1] = (fmx1 & Keep6) | (fmx1 >> 6);
		q[1][1] = (fmn1 & Keep6) | (fmn1 >> 6);
		for (int c = 0; c < 2; c++) begin
			q[2][c] = div3(10'(2 * q[0][c]) + 10'(q[1][c]));
			q[3][c] = div3(10'd1 + 10'(q[0][c]) + 10'(2 * q[1][c]));
		end
		pco = store_q[fin_idx_q][23:16];
		pcg = store_q[fin_idx_q][15:8];
		if (dxt5_q) begin
			pco = scale_mid(pco, s_q);
			pcg = scale_mid(pcg, s_q);
		end
		for (int k = 0; k < 4; k++)
			e[k] = 10'(absd(q[k][0], pco)) + 10'(absd(q[k][1], pcg));
		cv2 = {((e[1] > e[2]) & (e[0] > e[2])) | ((e[0] > e[3]) & (e[1] > e[3])),
			(e[0] > e[3]) & (e[2] > e[3])};
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			for (int c = 0; c < 2; c++)
				p_q[k][c] <= q[k][c];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpass_q   <= 1'b0;
			fin_idx_q <= '0;
		end else if (cmd.walk && cmd.idx == 4'(NumPix - 1)) begin
			cpass_q   <= 1'b1;
			fin_idx_q <= '0;
		end else if (cpass_q) begin
			fin_idx_q <= fin_idx_q + 4'd1;
			if (fin_idx_q == 4'(NumPix - 1))
				cpass_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cpass_q)
			cbits_q[2*fin_idx_q +: 2] <= cv2;
	end
	logic unused;
	assign unused = ^{cv, tsum, pe[0][1], pe[1][1]};
endmodule

FILE: rtl/ycocg_dxt_block_compressor.sv
// Top level of the YCoCg DXT block compressor.
// After the 16th pixel transaction a block passes through prep, scale,
// thresholds, the diagonal/alpha pass, the color index pass and finish.
// Throughput: one pixel per cycle while loading; input is held off from the 16th
// pixel until finish, longer while an earlier result is stalled.
// Reset clears bounds, counters and mode; the pixel store is not reset.
module ycocg_dxt_block_compressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  co_byte,
	input  logic [7:0]  cg_byte,
	input  logic [7:0]  spare_byte,
	input  logic [7:0]  luma_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] alpha_block,
	output logic [63:0] color_block
);
	import ycdxt_pkg::*;

	logic    format_mode_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			format_mode_q <= 1'b0;
		else if (cfg_we)
			format_mode_q <= cfg_wdata;
	end

	ycdxt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd
	);

	ycdxt_dpath u_dpath (
		.clk, .arst_n, .format_mode(format_mode_q),
		.co_byte, .cg_byte, .spare_byte, .luma_byte,
		.cmd, .sts, .alpha_block, .color_block
	);

`ifndef SYNTHESIS
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> in_stall) else $error("load during coding pass");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(color_block))
		else $error("result lost while stalled");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.prep, cmd.scale, cmd.thresh, cmd.walk}))
		else $error("overlapping datapath commands");
`endif
endmodule
